// ===== hdl/token_sequence_pattern_table_defines.svh =====
// ----------------------------------------------------------------------------
// Token sequence pattern table: assertion macros
// Shared concurrent assertion forms. Each one samples on clk and is disabled
// while rst is high.
// ----------------------------------------------------------------------------
`ifndef TOKEN_SEQUENCE_PATTERN_TABLE_DEFINES_SVH
`define TOKEN_SEQUENCE_PATTERN_TABLE_DEFINES_SVH

// The condition holds at every clock edge.
`define TSPT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequence holds in the same cycle as the antecedent.
`define TSPT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define TSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tspt_pkg.sv =====
// ----------------------------------------------------------------------------
// Token sequence pattern table package
// Field widths, result status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tspt_pkg;

  localparam int TOKEN_W     = 32;
  localparam int LEN_W       = 4;
  localparam int TAG_W       = 32;
  localparam int HITS_W      = 32;
  localparam int INDEX_W     = 5;
  localparam int STATUS_W    = 3;
  localparam int TOKEN_PORTS = 8;

  localparam int DEF_TABLE_ENTRIES = 32;
  localparam int DEF_MAX_TOKENS    = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_LEARNED = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_BADLEN  = 3'd3,
    ST_MATCH   = 3'd4,
    ST_NOMATCH = 3'd5
  } status_t;

  // How the search of a transaction ended.
  typedef enum logic [1:0] {
    OUT_HIT,
    OUT_MISS,
    OUT_BADLEN
  } outcome_t;

  typedef struct packed {
    logic     load;
    logic     scan;
    logic     finish;
    outcome_t outcome;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad_len;
    logic hit;
    logic exhausted;
  } dp_status_t;

endpackage

// ===== hdl/tspt_datapath.sv =====
// ----------------------------------------------------------------------------
// Token sequence pattern table datapath
// Request registers, entry and hit counter memories, the pipelined entry
// compare and the result registers.
// ----------------------------------------------------------------------------
`include "token_sequence_pattern_table_defines.svh"

module tspt_datapath
  import tspt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int MAX_TOKENS    = DEF_MAX_TOKENS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ctrl_cmd_t                         cmd,
  output dp_status_t                        stat,
  input  logic                              req_type,
  input  logic [TOKEN_PORTS-1:0][TOKEN_W-1:0] tokens,
  input  logic [LEN_W-1:0]                  seq_len,
  input  logic [TAG_W-1:0]                  result_tag,
  output logic [STATUS_W-1:0]               res_status,
  output logic [INDEX_W-1:0]                res_index,
  output logic [HITS_W-1:0]                 res_hits,
  output logic [TAG_W-1:0]                  res_tag
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef logic [MAX_TOKENS-1:0][TOKEN_W-1:0] row_tokens_t;

  // Entry memories share one address; hit counters are a separate memory.
  row_tokens_t       tok_mem  [TABLE_ENTRIES];
  logic [LEN_W-1:0]  len_mem  [TABLE_ENTRIES];
  logic [TAG_W-1:0]  tag_mem  [TABLE_ENTRIES];
  logic [HITS_W-1:0] hits_mem [TABLE_ENTRIES];

  logic              req_type_q;
  row_tokens_t       tok_q;
  logic [LEN_W-1:0]  len_q;
  logic [TAG_W-1:0]  tag_q;

  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  scan_idx;
  logic              rd_pend;
  logic [IDX_W-1:0]  cmp_idx;

  row_tokens_t       row_tok_q;
  logic [LEN_W-1:0]  row_len_q;
  logic [TAG_W-1:0]  row_tag_q;
  logic [HITS_W-1:0] hits_q;

  logic              issue;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              full;
  logic              row_match;
  logic [HITS_W-1:0] bumped;
  logic [IDX_W+INDEX_W-1:0] cmp_idx_ext;
  logic [IDX_W+INDEX_W-1:0] wr_addr_ext;

  assign issue   = cmd.scan && (scan_idx < used);
  assign rd_addr = scan_idx[IDX_W-1:0];
  assign wr_addr = used[IDX_W-1:0];
  assign full    = (used == CNT_W'(TABLE_ENTRIES));
  assign bumped  = (hits_q == '1) ? hits_q : hits_q + 1'b1;

  assign cmp_idx_ext = {{INDEX_W{1'b0}}, cmp_idx};
  assign wr_addr_ext = {{INDEX_W{1'b0}}, wr_addr};

  // Tokens past the request length do not take part in the compare.
  always_comb begin
    row_match = (row_len_q == len_q);
    for (int j = 0; j < MAX_TOKENS; j++) begin
      if ((LEN_W'(j) < len_q) && (row_tok_q[j] != tok_q[j])) begin
        row_match = 1'b0;
      end
    end
  end

  assign stat.bad_len   = (len_q == '0) || (len_q > LEN_W'(MAX_TOKENS));
  assign stat.hit       = rd_pend && row_match;
  assign stat.exhausted = !rd_pend && !(scan_idx < used);

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
        rd_pend  <= 1'b0;
      end else if (cmd.scan) begin
        rd_pend <= issue;
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (cmd.finish && (cmd.outcome == OUT_MISS) && !req_type_q && !full) begin
        used <= used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_q <= req_type;
      tok_q      <= tokens[MAX_TOKENS-1:0];
      len_q      <= seq_len;
      tag_q      <= result_tag;
    end

    if (issue) begin
      cmp_idx   <= rd_addr;
      row_tok_q <= tok_mem[rd_addr];
      row_len_q <= len_mem[rd_addr];
      row_tag_q <= tag_mem[rd_addr];
      hits_q    <= hits_mem[rd_addr];
    end

    if (cmd.finish) begin
      unique case (cmd.outcome)
        OUT_HIT: begin
          hits_mem[cmp_idx] <= bumped;
          res_status <= req_type_q ? ST_MATCH : ST_PRESENT;
          res_index  <= cmp_idx_ext[INDEX_W-1:0];
          res_hits   <= bumped;
          res_tag    <= row_tag_q;
        end
        OUT_MISS: begin
          res_tag <= '0;
          if (!req_type_q && !full) begin
            tok_mem[wr_addr]  <= tok_q;
            len_mem[wr_addr]  <= len_q;
            tag_mem[wr_addr]  <= tag_q;
            hits_mem[wr_addr] <= HITS_W'(1);
            res_status <= ST_LEARNED;
            res_index  <= wr_addr_ext[INDEX_W-1:0];
            res_hits   <= HITS_W'(1);
          end else begin
            res_status <= req_type_q ? ST_NOMATCH : ST_FULL;
            res_index  <= '0;
            res_hits   <= '0;
          end
        end
        OUT_BADLEN: begin
          res_status <= req_type_q ? ST_NOMATCH : ST_BADLEN;
          res_index  <= '0;
          res_hits   <= '0;
          res_tag    <= '0;
        end
        default: begin
          res_status <= ST_NOMATCH;
          res_index  <= '0;
          res_hits   <= '0;
          res_tag    <= '0;
        end
      endcase
    end
  end

  `TSPT_ASSERT_ALWAYS(a_used_in_range, used <= CNT_W'(TABLE_ENTRIES), "entry count beyond table size")
  `TSPT_ASSERT_IMPLY(a_hit_has_data, cmd.finish && (cmd.outcome == OUT_HIT), rd_pend, "hit finished without a compared entry")
  `TSPT_ASSERT_NEXT(a_used_only_on_finish, !cmd.finish, $stable(used), "entry count changed outside a finish")

endmodule

// ===== hdl/tspt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Token sequence pattern table controller
// Sequences load, entry scan and finish for one transaction at a time.
// ----------------------------------------------------------------------------
`include "token_sequence_pattern_table_defines.svh"

module tspt_ctrl
  import tspt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  output ctrl_cmd_t  cmd,
  input  dp_status_t stat
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.scan    = 1'b0;
    cmd.finish  = 1'b0;
    cmd.outcome = OUT_MISS;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.bad_len) begin
          cmd.finish  = 1'b1;
          cmd.outcome = OUT_BADLEN;
          state_next  = S_IDLE;
        end else if (stat.hit) begin
          cmd.finish  = 1'b1;
          cmd.outcome = OUT_HIT;
          state_next  = S_IDLE;
        end else if (stat.exhausted) begin
          cmd.finish  = 1'b1;
          cmd.outcome = OUT_MISS;
          state_next  = S_IDLE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= cmd.finish;
    end
  end

  `TSPT_ASSERT_IMPLY(a_done_after_busy, done, $past(busy), "result strobe without a transaction")
  `TSPT_ASSERT_NEXT(a_load_sets_busy, cmd.load, busy, "accepted transaction did not raise busy")

endmodule

// ===== hdl/token_sequence_pattern_table.sv =====
// ----------------------------------------------------------------------------
// Token sequence pattern table
// Learns token sequences of one to eight tokens with a tag and a saturating
// hit counter, and looks them up in insertion order.
// ----------------------------------------------------------------------------
// A transaction is accepted at a clock edge where start is high and busy is
// low; busy then stays high until the search is over. Every transaction
// gives exactly one result, shown on status, entry_index, hit_total and
// cached_tag for the single cycle in which done is high. The receiver cannot
// stall, so it must take the result in that cycle; the result ports hold no
// meaning outside it. A transaction that ends on a hit stops the scan at the
// matching entry, and one that finds nothing scans every entry in use. The
// entry memory has one read port and is scanned one entry per cycle, with
// the compare pipelined behind its registered read. A bad length finishes
// before any entry is read. A new transaction may be accepted in the cycle
// in which done is high.

module token_sequence_pattern_table
  import tspt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int MAX_TOKENS    = DEF_MAX_TOKENS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  logic                req_type,
  input  logic [TOKEN_W-1:0]  token_0,
  input  logic [TOKEN_W-1:0]  token_1,
  input  logic [TOKEN_W-1:0]  token_2,
  input  logic [TOKEN_W-1:0]  token_3,
  input  logic [TOKEN_W-1:0]  token_4,
  input  logic [TOKEN_W-1:0]  token_5,
  input  logic [TOKEN_W-1:0]  token_6,
  input  logic [TOKEN_W-1:0]  token_7,
  input  logic [LEN_W-1:0]    seq_len,
  input  logic [TAG_W-1:0]    result_tag,
  output logic [STATUS_W-1:0] status,
  output logic [INDEX_W-1:0]  entry_index,
  output logic [HITS_W-1:0]   hit_total,
  output logic [TAG_W-1:0]    cached_tag
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  // The token ports gathered into one vector, first token at index zero.
  logic [TOKEN_PORTS-1:0][TOKEN_W-1:0] tokens;

  assign tokens = {token_7, token_6, token_5, token_4,
                   token_3, token_2, token_1, token_0};

  // The controller decides when to load, scan and finish; the datapath holds
  // the table and tells it whether the current entry hit or the scan ran out.
  tspt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  tspt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_TOKENS    (MAX_TOKENS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .tokens     (tokens),
    .seq_len    (seq_len),
    .result_tag (result_tag),
    .res_status (status),
    .res_index  (entry_index),
    .res_hits   (hit_total),
    .res_tag    (cached_tag)
  );

endmodule
